// ===== hw/rtl/rplot_pkg.sv =====
// Package: sequencer states and widths for the root-pair lattice offset test unit.
package rplot_pkg;

    localparam int unsigned PRIME_BITS_DEF = 32;
    localparam int unsigned WORD_W         = 64;
    localparam int unsigned CNT_W          = 7;
    localparam int unsigned COEF_W         = 66;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_CHK,
        ST_DLR,
        ST_DSR,
        ST_DA,
        ST_ECHK,
        ST_EUC,
        ST_FIN,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/root_pair_lattice_offset_test_unit.sv =====
// Top level: bit-serial modular inverse and offset test over one root pair.
//
// One beat is taken when start is high and busy is low; busy stays high until
// the result strobe o_done, which lasts one cycle and cannot be held off.
// The primes are first squared bit-serially, followed by a check state, then
// three bit-serial reductions modulo q^2 (both roots and p^2), then
// extended-Euclid steps (each a check state plus one restoring division with
// the cofactor product formed alongside), a closing check state and a state
// to settle the inverse, then the bit-serial modular product and an output
// state. An item with q^2 == 0 finishes right after the squaring and its check
// state; an item without an inverse skips the product. The reductions and the
// Euclid divisions share the one-bit-per-cycle divider; the product uses the
// one-bit-per-cycle modular multiplier.
module root_pair_lattice_offset_test_unit #(
    parameter int unsigned PRIME_BITS = rplot_pkg::PRIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_small_prime,
    input  logic [31:0] i_large_prime,
    input  logic [63:0] i_small_root,
    input  logic [63:0] i_large_root,
    input  logic [31:0] i_offset_bound,
    output logic        o_done,
    output logic        o_hit,
    output logic [63:0] o_offset,
    output logic        o_no_inverse
);
    import rplot_pkg::*;

    localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(PRIME_BITS - 1);
    localparam logic [CNT_W-1:0] WORD_LAST = CNT_W'(WORD_W - 1);

    // a + b mod m for a, b < m
    function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] m);
        logic [WORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m}) begin
            sum = sum - {1'b0, m};
        end
        return sum[WORD_W-1:0];
    endfunction

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    logic [PRIME_BITS-1:0] r_p, r_q, r_shp, r_shq;
    logic [WORD_W-1:0]     r_p2, r_q2;
    logic [WORD_W-1:0]     r_lr, r_sr;
    logic [31:0]           r_bound;

    // divider
    logic [WORD_W-1:0]        r_dq, r_den, r_rem;
    logic signed [COEF_W-1:0] r_prod;
    // extended Euclid
    logic [WORD_W-1:0]        r_r0, r_r1;
    logic signed [COEF_W-1:0] r_t0, r_t1;
    // modular multiplier
    logic [WORD_W-1:0]        r_acc, r_x, r_mb;

    logic                  r_hit, r_no_inv;
    logic [WORD_W-1:0]     r_offset;

    logic [WORD_W:0]          rem_sh;
    logic                     qbit;
    logic [WORD_W-1:0]        rem_nx;
    logic signed [COEF_W-1:0] prod_nx;
    logic [WORD_W-1:0]        acc_nx, x_nx, diff, inv;
    logic signed [COEF_W-1:0] t_fix;
    logic                     last_word;

    // one restoring division step, cofactor product built from quotient bits
    always_comb begin
        rem_sh  = {r_rem, r_dq[WORD_W-1]};
        qbit    = (rem_sh >= {1'b0, r_den});
        rem_nx  = qbit ? WORD_W'(rem_sh - {1'b0, r_den}) : rem_sh[WORD_W-1:0];
        prod_nx = (r_prod <<< 1) + (qbit ? r_t1 : COEF_W'(0));
    end

    // one modular multiply step, LSB first
    always_comb begin
        acc_nx = r_mb[0] ? add_mod(r_acc, r_x, r_q2) : r_acc;
        x_nx   = add_mod(r_x, r_x, r_q2);
    end

    // root difference and positive inverse
    always_comb begin
        diff  = (r_lr >= r_sr) ? (r_lr - r_sr) : (r_lr + (r_q2 - r_sr));
        t_fix = r_t0 + $signed({2'b00, r_q2});
        inv   = (r_t0 < 0) ? t_fix[WORD_W-1:0] : r_t0[WORD_W-1:0];
    end

    assign last_word = (r_cnt == WORD_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = ST_SQR;
            ST_SQR:  if (r_cnt == SQR_LAST) n_state = ST_CHK;
            ST_CHK:  n_state = (r_q2 == '0) ? ST_OUT : ST_DLR;
            ST_DLR:  if (last_word) n_state = ST_DSR;
            ST_DSR:  if (last_word) n_state = ST_DA;
            ST_DA:   if (last_word) n_state = ST_ECHK;
            ST_ECHK: n_state = (r_r1 == '0) ? ST_FIN : ST_EUC;
            ST_EUC:  if (last_word) n_state = ST_ECHK;
            ST_FIN:  n_state = (r_r0 != WORD_W'(1)) ? ST_OUT : ST_MUL;
            ST_MUL:  if (last_word) n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        busy   = (r_state != ST_IDLE);
        o_done = (r_state == ST_OUT);
    end

    assign o_hit        = r_hit;
    assign o_offset     = r_offset;
    assign o_no_inverse = r_no_inv;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_p     <= i_small_prime[PRIME_BITS-1:0];
                r_q     <= i_large_prime[PRIME_BITS-1:0];
                r_shp   <= i_small_prime[PRIME_BITS-1:0];
                r_shq   <= i_large_prime[PRIME_BITS-1:0];
                r_lr    <= i_large_root;
                r_sr    <= i_small_root;
                r_bound <= i_offset_bound;
                r_p2    <= '0;
                r_q2    <= '0;
                r_cnt   <= '0;
            end
            ST_SQR: begin
                // square both primes, MSB first
                r_p2  <= {r_p2[WORD_W-2:0], 1'b0}
                         + (r_shp[PRIME_BITS-1] ? WORD_W'(r_p) : WORD_W'(0));
                r_q2  <= {r_q2[WORD_W-2:0], 1'b0}
                         + (r_shq[PRIME_BITS-1] ? WORD_W'(r_q) : WORD_W'(0));
                r_shp <= r_shp << 1;
                r_shq <= r_shq << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_CHK: begin
                r_hit    <= 1'b0;
                r_offset <= '0;
                r_no_inv <= 1'b1;
                r_dq     <= r_lr;
                r_den    <= r_q2;
                r_rem    <= '0;
                r_prod   <= '0;
                r_cnt    <= '0;
            end
            ST_DLR, ST_DSR, ST_DA, ST_EUC: begin
                r_dq   <= {r_dq[WORD_W-2:0], qbit};
                r_rem  <= rem_nx;
                r_prod <= prod_nx;
                r_cnt  <= r_cnt + 1'b1;
                if (last_word) begin
                    r_rem  <= '0;
                    r_prod <= '0;
                    r_cnt  <= '0;
                    r_den  <= r_q2;
                    case (r_state)
                        ST_DLR: begin
                            r_lr <= rem_nx;
                            r_dq <= r_sr;
                        end
                        ST_DSR: begin
                            r_sr <= rem_nx;
                            r_dq <= r_p2;
                        end
                        ST_DA: begin
                            r_r0 <= r_q2;
                            r_r1 <= rem_nx;
                            r_t0 <= '0;
                            r_t1 <= COEF_W'(1);
                        end
                        default: begin
                            r_r0 <= r_r1;
                            r_r1 <= rem_nx;
                            r_t0 <= r_t1;
                            r_t1 <= r_t0 - prod_nx;
                        end
                    endcase
                end
            end
            ST_ECHK: begin
                // load the next Euclid division
                r_dq   <= r_r0;
                r_den  <= r_r1;
                r_rem  <= '0;
                r_prod <= '0;
                r_cnt  <= '0;
            end
            ST_FIN: begin
                r_acc <= '0;
                r_x   <= diff;
                r_mb  <= inv;
                r_cnt <= '0;
            end
            ST_MUL: begin
                r_acc <= acc_nx;
                r_x   <= x_nx;
                r_mb  <= r_mb >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (last_word) begin
                    r_offset <= acc_nx;
                    r_hit    <= (acc_nx < {32'd0, r_bound});
                    r_no_inv <= 1'b0;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

// ===== verif/testbench.sv =====
// Testbench for the root-pair lattice offset test unit: directed and random beats.
`timescale 1ns / 1ps

module testbench;
    import rplot_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [63:0] offset;
        logic        no_inverse;
    } t_offset_result;

    // Hold expected offsets in beat order and compare each result strobe
    class offset_scoreboard;
        t_offset_result pending[$];
        int             errors;
        int             checked;
        int             hits;
        int             no_inverses;

        function new();
            errors      = 0;
            checked     = 0;
            hits        = 0;
            no_inverses = 0;
        endfunction

        function void note_beat(t_offset_result exp_res);
            pending.push_back(exp_res);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic hit, logic [63:0] offset, logic no_inverse);
            t_offset_result want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", {63'd0, hit}, 64'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.hit) hits++;
            if (want.no_inverse) no_inverses++;
            if (hit !== want.hit) report_mismatch("hit", {63'd0, hit}, {63'd0, want.hit});
            if (offset !== want.offset) report_mismatch("offset", offset, want.offset);
            if (no_inverse !== want.no_inverse)
                report_mismatch("no_inverse", {63'd0, no_inverse}, {63'd0, want.no_inverse});
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_small_prime;
    logic [31:0] i_large_prime;
    logic [63:0] i_small_root;
    logic [63:0] i_large_root;
    logic [31:0] i_offset_bound;
    logic        o_done;
    logic        o_hit;
    logic [63:0] o_offset;
    logic        o_no_inverse;

    offset_scoreboard offsets = new();

    root_pair_lattice_offset_test_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_small_prime  (i_small_prime),
        .i_large_prime  (i_large_prime),
        .i_small_root   (i_small_root),
        .i_large_root   (i_large_root),
        .i_offset_bound (i_offset_bound),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_offset       (o_offset),
        .o_no_inverse   (o_no_inverse)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Invert p^2 modulo q^2 by extended Euclid, then scale the root difference
    function automatic t_offset_result predict_offset(
        input logic [31:0] p, input logic [31:0] q,
        input logic [63:0] s_root, input logic [63:0] l_root, input logic [31:0] bound);
        t_offset_result    res;
        logic [63:0]       q2;
        logic [63:0]       p2;
        logic [63:0]       inv;
        logic [63:0]       a;
        logic [63:0]       b;
        logic [63:0]       diff;
        logic [127:0]      prod;
        logic signed [131:0] r0, r1, r2, t0, t1, t2, qt;
        res = '0;
        q2 = {32'd0, q} * {32'd0, q};
        p2 = {32'd0, p} * {32'd0, p};
        if (q2 == 64'd0) begin
            res.no_inverse = 1'b1;
            return res;
        end
        r0 = $signed({68'd0, q2});
        r1 = $signed({68'd0, p2 % q2});
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            r2 = r0 - qt * r1;
            t2 = t0 - qt * t1;
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        if (r0 != 1) begin
            res.no_inverse = 1'b1;
            return res;
        end
        if (t0 < 0) t0 = t0 + $signed({68'd0, q2});
        inv = t0[63:0];
        a = l_root % q2;
        b = s_root % q2;
        diff = (a >= b) ? (a - b) : (a + (q2 - b));
        prod = {64'd0, diff} * {64'd0, inv};
        res.offset = 64'(prod % {64'd0, q2});
        res.hit = (res.offset < {32'd0, bound});
        return res;
    endfunction

    // Drive one beat and hold until it is taken; start stays high afterward
    task automatic send_beat(logic [31:0] p, logic [31:0] q, logic [63:0] s_root,
                             logic [63:0] l_root, logic [31:0] bound);
        start          <= 1'b1;
        i_small_prime  <= p;
        i_large_prime  <= q;
        i_small_root   <= s_root;
        i_large_root   <= l_root;
        i_offset_bound <= bound;
        do @(posedge i_clk); while (busy !== 1'b0);
        offsets.note_beat(predict_offset(p, q, s_root, l_root, bound));
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick a random beat, mostly coprime primes-like values, plus degenerate ones
    task automatic send_random_beat();
        logic [31:0]    p, q, bound;
        logic [63:0]    s_root, l_root;
        t_offset_result guess;
        int             kind;
        kind = $urandom_range(0, 99);
        p = $urandom | 32'd1;
        q = $urandom | 32'd1;
        if (kind < 15) begin
            p = $urandom_range(0, 255);
            q = $urandom_range(0, 255);
        end else if (kind < 20) begin
            q = p;
        end else if (kind < 25) begin
            q = $urandom;
            p = $urandom;
        end else if (kind < 28) begin
            q = q * 3;
            p = p * 3;
        end
        s_root = rand64();
        l_root = rand64();
        if (kind >= 90) begin
            s_root = s_root % ({32'd0, p} * {32'd0, p} + 64'd1);
            l_root = l_root % ({32'd0, q} * {32'd0, q} + 64'd1);
        end
        bound = $urandom;
        guess = predict_offset(p, q, s_root, l_root, 32'd0);
        // Aim the bound at the offset now and then so hits and near misses occur
        if (!guess.no_inverse && guess.offset < 64'h1_0000_0000 && $urandom_range(0, 1))
            bound = guess.offset[31:0] + 32'($urandom_range(0, 1));
        send_beat(p, q, s_root, l_root, bound);
    endtask

    // Compare every result strobe in the cycle it is shown
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            offsets.check_result(o_hit, o_offset, o_no_inverse);
        end
    end

    initial begin
        #300_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int idle_pct;
        start          = 1'b0;
        i_small_prime  = '0;
        i_large_prime  = '0;
        i_small_root   = '0;
        i_large_root   = '0;
        i_offset_bound = '0;
        i_rst_n        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: degenerate moduli, shared factors, field extremes
        send_beat(32'd3, 32'd3, 64'd5, 64'd7, 32'hFFFF_FFFF);
        send_beat(32'd0, 32'd7, 64'd1, 64'd2, 32'hFFFF_FFFF);
        send_beat(32'd5, 32'd0, 64'd1, 64'd2, 32'hFFFF_FFFF);
        send_beat(32'd5, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 32'd0);
        send_beat(32'd5, 32'd1, 64'd0, 64'd3, 32'd1);
        send_beat(32'd3, 32'd2, 64'd1, 64'd3, 32'd2);
        send_beat(32'd3, 32'd4, 64'd4, 64'd15, 32'd16);
        send_beat(32'd2, 32'd3, 64'd0, 64'd8, 32'd9);
        send_beat(32'd6, 32'd9, 64'd10, 64'd20, 32'hFFFF_FFFF);
        send_beat(32'd7, 32'd5, 64'd48, 64'd24, 32'd25);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd5);
        send_beat(32'hFFFF_FFFB, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFB, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_beat(32'd1, 32'hFFFF_FFFB, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h5555_5555_5555_5555, 32'h8000_0000);
        send_beat(32'd11, 32'd13, 64'd7, 64'd7, 32'd1);
        send_beat(32'd11, 32'd13, 64'd7, 64'd7, 32'd0);
        send_beat(32'd2, 32'h8000_0000, 64'd1, 64'd0, 32'hFFFF_FFFF);
        send_beat(32'h7FFF_FFFF, 32'h8000_0000, 64'h8000_0000_0000_0000, 64'd1, 32'd1);

        // Pause until the pipeline drains, then run random phases at set idle rates
        start <= 1'b0;
        while (offsets.pending.size() != 0) @(posedge i_clk);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 60 : (phase == 3) ? 9 : 0;
            for (int n = 0; n < 320; n++) begin
                send_random_beat();
                if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 200));
            end
        end
        start <= 1'b0;

        while (offsets.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d offsets: %0d hits, %0d without an inverse",
                 offsets.checked, offsets.hits, offsets.no_inverses);
        $display("Idle rates of 0, 60 and 9 percent, one full drain pause");
        if (offsets.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/rplot_pkg.sv
hw/rtl/root_pair_lattice_offset_test_unit.sv
verif/testbench.sv
